// ===== rtl/core/four_level_page_table_walker_top_assert.svh =====
// Assertion macros for the page table walker checker.
// No dependencies; included by the checker file.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define PTW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PTW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ptw_pkg.sv =====
// Shared types, constants and helper functions for the page table walker.
// No dependencies.
package ptw_pkg;

   localparam int IDX_W           = 9;
   localparam int WORDS_PER_FRAME = 512;
   localparam int PAGE_SHIFT      = 12;
   localparam int VA_W            = 48;
   localparam int PA_W            = 19;
   localparam int WIDX_W          = 16;
   localparam int DATA_W          = 64;
   localparam int STATUS_W        = 2;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 7;

   localparam logic [IDX_W-1:0]  IDX_MASK  = 9'h1FF;
   localparam logic [DATA_W-1:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF_F000;

   localparam int SHIFT_L4 = 39;
   localparam int SHIFT_L3 = 30;
   localparam int SHIFT_L2 = 21;
   localparam int SHIFT_L1 = 12;

   localparam logic [DATA_W-1:0] BIT_P = 64'h1;
   localparam logic [DATA_W-1:0] BIT_W = 64'h2;
   localparam logic [DATA_W-1:0] BIT_U = 64'h4;

   // level counter: 0 is the top table, 3 the leaf table
   localparam logic [1:0] LEAF_LEVEL = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_FRAME = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOC_BASE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_USER_MODE  = 2'd2;

   typedef enum logic [1:0] {
      OP_MAP,
      OP_TRANSLATE,
      OP_WRITE_WORD,
      OP_READ_WORD
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_NO_FRAME,
      STATUS_OUTSIDE
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WORD,
      S_WORD_RD,
      S_START,
      S_WALK,
      S_EVAL,
      S_ZERO,
      S_LINK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [1:0] lvl);
      logic [VA_W-1:0] shifted;
      case (lvl)
         2'd0:    shifted = va >> SHIFT_L4;
         2'd1:    shifted = va >> SHIFT_L3;
         2'd2:    shifted = va >> SHIFT_L2;
         default: shifted = va >> SHIFT_L1;
      endcase
      return IDX_W'(shifted & VA_W'(IDX_MASK));
   endfunction

   function automatic logic [DATA_W-1:0] link_flags(input logic user);
      return BIT_P | BIT_W | (user ? BIT_U : '0);
   endfunction

endpackage

// ===== rtl/core/ptw_chan_if.sv =====
// Channel interfaces of the page table walker: request, response, CSR write.
// Depends on ptw_pkg.
interface ptw_req_if import ptw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [VA_W-1:0]     virt_addr;
   logic [PA_W-1:0]     phys_addr;
   logic [WIDX_W-1:0]   word_index;
   logic [DATA_W-1:0]   word_data;

   modport source (output valid, operation, virt_addr, phys_addr, word_index, word_data,
                   input ready);
   modport sink   (input valid, operation, virt_addr, phys_addr, word_index, word_data,
                   output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   entry_value;
   logic                found;
   logic [STATUS_W-1:0] status;

   modport source (output valid, entry_value, found, status, input ready);
   modport sink   (input valid, entry_value, found, status, output ready);
endinterface

interface ptw_csr_if import ptw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/four_level_page_table_walker_top.sv =====
// Four-level page table walker: sequencer, config registers, response register.
// Depends on ptw_pkg, ptw_chan_if and ptw_mem.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        operation, virt_addr, phys_addr, word_index, word_data
//   rsp_chan  out   valid/ready        entry_value, found, status
//   csr_chan  in    valid/ready (=1)   index, data
//
// All table accesses go through one single-port memory, so each level read takes a WALK state
// that sends the address and an EVAL state on the registered read data. Map allocates a
// missing table by clearing its 512 words (ZERO) and writing the link (LINK). Word write
// uses the WORD state alone; word read adds WORD_RD for the registered read data.
// After reset a clearing pass zeroes PHYS_FRAMES*512 words with req_chan.ready low; CSR
// writes are taken throughout.
// The response sits in an output register, so the next transaction can start
// while it waits; a finished transaction holds in DONE only if that register is full.
module four_level_page_table_walker_top import ptw_pkg::*; #(
   parameter int PHYS_FRAMES = 128
) (
   input  logic     clock,
   input  logic     reset,
   ptw_req_if.sink  req_chan,
   ptw_rsp_if.source rsp_chan,
   ptw_csr_if.sink  csr_chan
);

   localparam int unsigned MEM_WORDS = PHYS_FRAMES * WORDS_PER_FRAME;
   localparam int FRAME_W = $clog2(PHYS_FRAMES);
   localparam int ADDR_W  = FRAME_W + IDX_W;
   // wide enough for any 7-bit frame register value and for PHYS_FRAMES itself
   localparam int NUM_W   = $clog2(PHYS_FRAMES + 128);

   // sequencer and walk state
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic [PA_W-1:0]     pa_ff, pa_in;
   logic [WIDX_W-1:0]   widx_ff, widx_in;
   logic [DATA_W-1:0]   wdata_ff, wdata_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [1:0]          lvl_ff, lvl_in;
   logic                all_ff, all_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;

   // configuration
   logic [CSR_DATA_W-1:0] root_ff, root_in;
   logic                  user_ff, user_in;
   logic [NUM_W-1:0]      nf_ff, nf_in;

   // finished result and response register
   logic [DATA_W-1:0]   res_value_ff, res_value_in;
   logic                res_found_ff, res_found_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_found_ff, rsp_found_in;
   status_type          rsp_status_ff, rsp_status_in;

   // memory port
   mem_ctrl_type        mem_ctrl;
   logic [ADDR_W-1:0]   mem_addr;
   logic [DATA_W-1:0]   mem_wdata;
   logic [DATA_W-1:0]   mem_rdata;

   logic                req_fire;
   logic                csr_fire;
   logic                rsp_free;
   logic [ADDR_W-1:0]   walk_slot;
   logic [ADDR_W-1:0]   zero_addr;
   logic [DATA_W-1:0]   entry_page;
   logic                entry_present;
   logic                entry_outside;
   logic                root_outside;
   logic                nf_exhausted;
   logic                word_outside;
   logic                is_leaf;
   logic                clear_last;
   logic                zero_last;

   ptw_mem #(
      .DEPTH  (MEM_WORDS),
      .ADDR_W (ADDR_W)
   ) u_ptw_mem (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign walk_slot     = {frame_ff, level_index(va_ff, lvl_ff)};
   assign zero_addr     = {FRAME_W'(nf_ff), sweep_ff[IDX_W-1:0]};
   assign entry_page    = (mem_rdata & ADDR_MASK) >> PAGE_SHIFT;
   assign entry_present = |(mem_rdata & BIT_P);
   assign entry_outside = entry_page >= DATA_W'(PHYS_FRAMES);
   assign root_outside  = NUM_W'(root_ff) >= NUM_W'(PHYS_FRAMES);
   assign nf_exhausted  = nf_ff >= NUM_W'(PHYS_FRAMES);
   assign word_outside  = 32'(widx_ff) >= MEM_WORDS;
   assign is_leaf       = (lvl_ff == LEAF_LEVEL);
   assign clear_last    = (sweep_ff == ADDR_W'(MEM_WORDS - 1));
   assign zero_last     = (sweep_ff[IDX_W-1:0] == '1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_chan.operation) == OP_WRITE_WORD ||
                   op_type'(req_chan.operation) == OP_READ_WORD) begin
                  state_in = S_WORD;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_WORD: begin
            if (word_outside || op_ff == OP_WRITE_WORD) state_in = S_DONE;
            else state_in = S_WORD_RD;
         end
         S_WORD_RD: state_in = S_DONE;
         S_START: begin
            if (root_outside) state_in = S_DONE;
            else state_in = S_WALK;
         end
         S_WALK: begin
            if (is_leaf && op_ff == OP_MAP) state_in = S_DONE;
            else state_in = S_EVAL;
         end
         S_EVAL: begin
            if (is_leaf) begin
               state_in = S_DONE;
            end else if (entry_present) begin
               state_in = entry_outside ? S_DONE : S_WALK;
            end else if (op_ff == OP_TRANSLATE || nf_exhausted) begin
               state_in = S_DONE;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (zero_last) state_in = S_LINK;
         end
         S_LINK: state_in = S_WALK;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // datapath, memory port and result
   always_comb begin
      op_in         = op_ff;
      va_in         = va_ff;
      pa_in         = pa_ff;
      widx_in       = widx_ff;
      wdata_in      = wdata_ff;
      frame_in      = frame_ff;
      lvl_in        = lvl_ff;
      all_in        = all_ff;
      slot_in       = slot_ff;
      sweep_in      = sweep_ff;
      root_in       = root_ff;
      user_in       = user_ff;
      nf_in         = nf_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctrl      = '0;
      mem_addr      = walk_slot;
      mem_wdata     = '0;

      // config writes are expected only with no transaction in flight
      if (csr_fire) begin
         case (csr_chan.index)
            CSR_ROOT_FRAME: root_in = csr_chan.data;
            CSR_ALLOC_BASE: nf_in   = NUM_W'(csr_chan.data);
            CSR_USER_MODE:  user_in = csr_chan.data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_ctrl.wr_en = 1'b1;
            mem_addr       = sweep_ff;
            sweep_in       = sweep_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_chan.operation);
               va_in    = req_chan.virt_addr;
               pa_in    = req_chan.phys_addr;
               widx_in  = req_chan.word_index;
               wdata_in = req_chan.word_data;
            end
         end
         S_WORD: begin
            mem_addr      = ADDR_W'(widx_ff);
            res_value_in  = '0;
            res_found_in  = 1'b0;
            res_status_in = STATUS_OK;
            if (word_outside) begin
               res_status_in = STATUS_OUTSIDE;
            end else if (op_ff == OP_WRITE_WORD) begin
               mem_ctrl.wr_en = 1'b1;
               mem_wdata      = wdata_ff;
               res_value_in   = wdata_ff;
            end else begin
               mem_ctrl.rd_en = 1'b1;
            end
         end
         S_WORD_RD: res_value_in = mem_rdata;
         S_START: begin
            frame_in      = FRAME_W'(root_ff);
            lvl_in        = '0;
            all_in        = 1'b1;
            res_value_in  = '0;
            res_found_in  = 1'b0;
            res_status_in = root_outside ? STATUS_OUTSIDE : STATUS_OK;
         end
         S_WALK: begin
            slot_in = walk_slot;
            if (is_leaf && op_ff == OP_MAP) begin
               mem_ctrl.wr_en = 1'b1;
               mem_wdata      = DATA_W'(pa_ff) | link_flags(user_ff);
               res_value_in   = DATA_W'(pa_ff) | link_flags(user_ff);
               res_found_in   = all_ff;
            end else begin
               mem_ctrl.rd_en = 1'b1;
            end
         end
         S_EVAL: begin
            if (is_leaf) begin
               // translate leaf: raw entry, present or not
               res_value_in = mem_rdata;
               res_found_in = 1'b1;
            end else if (entry_present) begin
               frame_in = FRAME_W'(entry_page);
               lvl_in   = lvl_ff + 1'b1;
               if (entry_outside) res_status_in = STATUS_OUTSIDE;
            end else if (op_ff == OP_MAP) begin
               all_in   = 1'b0;
               sweep_in = '0;
               if (nf_exhausted) res_status_in = STATUS_NO_FRAME;
            end
         end
         S_ZERO: begin
            mem_ctrl.wr_en = 1'b1;
            mem_addr       = zero_addr;
            sweep_in       = sweep_ff + 1'b1;
         end
         S_LINK: begin
            mem_ctrl.wr_en = 1'b1;
            mem_addr       = slot_ff;
            mem_wdata      = (DATA_W'(FRAME_W'(nf_ff)) << PAGE_SHIFT) | link_flags(user_ff);
            frame_in       = FRAME_W'(nf_ff);
            nf_in          = nf_ff + 1'b1;
            lvl_in         = lvl_ff + 1'b1;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         root_ff      <= '0;
         user_ff      <= 1'b0;
         nf_ff        <= NUM_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         root_ff      <= root_in;
         user_ff      <= user_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      widx_ff       <= widx_in;
      wdata_ff      <= wdata_in;
      frame_ff      <= frame_in;
      lvl_ff        <= lvl_in;
      all_ff        <= all_in;
      slot_ff       <= slot_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_value = rsp_value_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

// ===== rtl/core/ptw_mem.sv =====
// Single-port table memory with registered read data.
// Depends on ptw_pkg.
module ptw_mem import ptw_pkg::*; #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  mem_ctrl_type      ctrl,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ptw_checker.sv =====
// Port-level checks for the page table walker, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker_top_assert.svh.
`include "four_level_page_table_walker_top_assert.svh"

module ptw_checker import ptw_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DATA_W-1:0]   rsp_entry_value,
   input logic                rsp_found,
   input logic [STATUS_W-1:0] rsp_status
);

   // clearing pass follows every reset
   `PTW_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready, "ready during clear")

   // one transaction in flight at a time
   `PTW_ASSERT(a_one_in_flight, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready after accept")

   // failed transactions report nothing else
   `PTW_ASSERT(a_error_zero, clock, reset, (rsp_valid && rsp_status != STATUS_OK) |-> (!rsp_found && rsp_entry_value == '0), "error result not cleared")

   `PTW_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_entry_value) && $stable(rsp_found) && $stable(rsp_status)), "response dropped or changed")

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_entry_value (rsp_chan.entry_value),
   .rsp_found       (rsp_chan.found),
   .rsp_status      (rsp_chan.status)
);
